### hw/rtl/bcf_pkg.sv
`timescale 1ns / 1ps
package bcf_pkg;

  localparam int MAX_ROWS_DEF    = 128;
  localparam int MAX_COLUMNS_DEF = 128;
  localparam int COORD_BITS_DEF  = 16;

  // working width of coordinate arithmetic before saturation
  localparam int WW = 40;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [14:0] LIMIT_RST = 15'd1024;
  localparam logic [14:0] PITCH_RST = 15'd16;
  localparam logic [7:0]  COUNT_RST = 8'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_ORIGIN = 3'd0,
    REG_X_PITCH  = 3'd1,
    REG_Y_ORIGIN = 3'd2,
    REG_Y_PITCH  = 3'd3,
    REG_COLUMNS  = 3'd4,
    REG_ROWS     = 3'd5,
    REG_MARGIN   = 3'd6,
    REG_LIMIT    = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_BOX   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_FILL,
    ST_IDLE,
    ST_SETUP,
    ST_HALF,
    ST_WALK,
    ST_DRAIN,
    ST_RD,
    ST_ROOT,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [9:0]         frame_number;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic signed [15:0] speed_x;
    logic signed [15:0] speed_y;
    logic [14:0]        half_size_x;
    logic [14:0]        half_size_y;
    logic [14:0]        base_spread;
    logic [14:0]        spread_growth;
    logic [6:0]         read_row;
    logic [6:0]         read_column;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] clearance;
    logic               inside_res;
  } out_item_t;

  function automatic logic signed [WW-1:0] sat_c(input logic signed [WW-1:0] v,
                                                 input int unsigned cw);
    logic signed [WW-1:0] hi;
    logic signed [WW-1:0] lo;
    hi = {{(WW-1){1'b0}}, 1'b1} <<< (cw - 1);
    hi = hi - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic logic signed [WW-1:0] sx16(input logic [15:0] v);
    return {{(WW-16){v[15]}}, v};
  endfunction

  function automatic logic signed [WW-1:0] zx15(input logic [14:0] v);
    return {{(WW-15){1'b0}}, v};
  endfunction

endpackage

### hw/rtl/box_clearance_field.sv
`timescale 1ns / 1ps
// Clearance grid against moving boxes. The per-cell depth and squared distance
// live in two single-port-write RAMs of MAX_ROWS*MAX_COLUMNS entries. After reset
// and after every clear op the block sweeps both RAMs, one cell per cycle,
// before it takes the next item; configuration writes are taken meanwhile. A box
// op runs a setup state and a half-size state, then one cell per cycle through a
// four-stage read-modify-write pipeline, then the drain. A read op outside the
// grid returns the limit; inside it, a cell inside a box returns its stored depth,
// and any other cell goes through the bit-serial square root, SQW being the
// squared-store width (31 at default). One item is worked at a time; a finished
// result waits in the output register.
module box_clearance_field #(
  parameter int MAX_ROWS    = bcf_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = bcf_pkg::MAX_COLUMNS_DEF,
  parameter int COORD_BITS  = bcf_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bcf_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bcf_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [bcf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bcf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int WW    = bcf_pkg::WW;
  localparam int CELLS = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int DW    = (COORD_BITS > 16) ? COORD_BITS : 16;
  localparam int SQW   = (2 * COORD_BITS - 1 > 30) ? 2 * COORD_BITS - 1 : 30;
  localparam int UW    = COORD_BITS - 1;
  localparam int RW    = (SQW + 1) / 2 + 1;
  localparam int CCW   = $clog2(MAX_COLUMNS + 1);
  localparam int CRW   = $clog2(MAX_ROWS + 1);

  // configuration
  logic [15:0] x_org_r, y_org_r;
  logic [14:0] x_pitch_r, y_pitch_r, margin_r, limit_r;
  logic [7:0]  cols_r, rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_org_r   <= '0;
      y_org_r   <= '0;
      x_pitch_r <= bcf_pkg::PITCH_RST;
      y_pitch_r <= bcf_pkg::PITCH_RST;
      cols_r    <= bcf_pkg::COUNT_RST;
      rows_r    <= bcf_pkg::COUNT_RST;
      margin_r  <= '0;
      limit_r   <= bcf_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      unique case (bcf_pkg::cfg_reg_t'(cfg_index))
        bcf_pkg::REG_X_ORIGIN: x_org_r   <= cfg_data;
        bcf_pkg::REG_X_PITCH:  x_pitch_r <= cfg_data[14:0];
        bcf_pkg::REG_Y_ORIGIN: y_org_r   <= cfg_data;
        bcf_pkg::REG_Y_PITCH:  y_pitch_r <= cfg_data[14:0];
        bcf_pkg::REG_COLUMNS:  cols_r    <= cfg_data[7:0];
        bcf_pkg::REG_ROWS:     rows_r    <= cfg_data[7:0];
        bcf_pkg::REG_MARGIN:   margin_r  <= cfg_data[14:0];
        bcf_pkg::REG_LIMIT:    limit_r   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  logic [CCW-1:0] cols_eff;
  logic [CRW-1:0] rows_eff;
  assign cols_eff = (32'(cols_r) > MAX_COLUMNS) ? CCW'(MAX_COLUMNS) : CCW'(cols_r);
  assign rows_eff = (32'(rows_r) > MAX_ROWS) ? CRW'(MAX_ROWS) : CRW'(rows_r);

  // control
  bcf_pkg::state_t state_r, state_nxt;
  bcf_pkg::in_item_t in_r;
  logic [9:0]  frame_r;
  logic [14:0] fill_val_r;
  logic [29:0] fill_sq_r;
  logic [AW-1:0] fill_addr_r;

  logic signed [WW-1:0] spread_r, px_r, py_r, hx_r, hy_r;
  logic signed [WW-1:0] acc_x_r, acc_y_r;
  logic [CCW-1:0] col_r;
  logic [CRW-1:0] row_r;
  logic [AW-1:0]  base_r;

  logic                 b_valid_r, c_valid_r, d_valid_r;
  logic signed [WW-1:0] b_sx_r, b_sy_r, c_gx_r, c_gy_r, d_gx_r, d_gy_r;
  logic [AW-1:0]        b_addr_r, c_addr_r, d_addr_r;
  logic [2*UW-1:0]      d_sqx_r, d_sqy_r;
  logic [DW-1:0]        d_dep_r;
  logic [SQW-1:0]       d_sq_r;

  bcf_pkg::out_item_t res_r, res_nxt, out_r;
  logic out_valid_r;

  logic in_fire, walk_fire, last_cell, root_start, res_load, out_load, fill_we;
  logic rd_far;
  logic [AW-1:0] rd_cell;

  // memories
  logic          dep_we, sq_we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] dep_wdata, dep_rdata;
  logic [SQW-1:0] sq_wdata, sq_rdata;

  bcf_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_dep_ram (
    .clk(clk), .we(dep_we), .waddr(waddr), .wdata(dep_wdata),
    .raddr(raddr), .rdata(dep_rdata)
  );

  bcf_ram #(.WIDTH(SQW), .DEPTH(CELLS)) u_sq_ram (
    .clk(clk), .we(sq_we), .waddr(waddr), .wdata(sq_wdata),
    .raddr(raddr), .rdata(sq_rdata)
  );

  logic          root_done;
  logic [RW-1:0] root_val;

  bcf_root #(.VW(SQW)) u_root (
    .clk(clk), .rst_n(rst_n), .start(root_start), .value(sq_rdata),
    .done(root_done), .root(root_val)
  );

  assign in_fire = in_valid && in_ready;
  assign rd_far  = (32'(in_data.read_row) >= MAX_ROWS) ||
                   (32'(in_data.read_column) >= MAX_COLUMNS);
  assign rd_cell = AW'(32'(in_data.read_row) * MAX_COLUMNS + 32'(in_data.read_column));
  assign last_cell = (row_r == CRW'(rows_eff - 1'b1)) && (col_r == CCW'(cols_eff - 1'b1));

  logic signed [WW-1:0] rd_dep_w;
  assign rd_dep_w = {{(WW-DW){dep_rdata[DW-1]}}, dep_rdata};

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    walk_fire  = 1'b0;
    root_start = 1'b0;
    res_load   = 1'b0;
    out_load   = 1'b0;
    fill_we    = 1'b0;
    res_nxt    = res_r;
    unique case (state_r)
      bcf_pkg::ST_FILL: begin
        fill_we = 1'b1;
        if (fill_addr_r == AW'(CELLS - 1)) state_nxt = bcf_pkg::ST_IDLE;
      end
      bcf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (bcf_pkg::op_t'(in_data.op))
            bcf_pkg::OP_CLEAR: state_nxt = bcf_pkg::ST_FILL;
            bcf_pkg::OP_BOX:   state_nxt = bcf_pkg::ST_SETUP;
            bcf_pkg::OP_READ: begin
              if (rd_far) begin
                res_load           = 1'b1;
                res_nxt.clearance  = signed'({1'b0, limit_r});
                res_nxt.inside_res = 1'b0;
                state_nxt          = bcf_pkg::ST_HOLD;
              end else begin
                state_nxt = bcf_pkg::ST_RD;
              end
            end
            default: ;
          endcase
        end
      end
      bcf_pkg::ST_SETUP: state_nxt = bcf_pkg::ST_HALF;
      bcf_pkg::ST_HALF: begin
        if (rows_eff == '0 || cols_eff == '0) state_nxt = bcf_pkg::ST_IDLE;
        else state_nxt = bcf_pkg::ST_WALK;
      end
      bcf_pkg::ST_WALK: begin
        walk_fire = 1'b1;
        if (last_cell) state_nxt = bcf_pkg::ST_DRAIN;
      end
      bcf_pkg::ST_DRAIN: begin
        if (!b_valid_r && !c_valid_r && !d_valid_r) state_nxt = bcf_pkg::ST_IDLE;
      end
      bcf_pkg::ST_RD: begin
        if (rd_dep_w <= 0) begin
          res_load           = 1'b1;
          res_nxt.clearance  = (rd_dep_w < -WW'(32768)) ? 16'sh8000 : rd_dep_w[15:0];
          res_nxt.inside_res = 1'b1;
          state_nxt          = bcf_pkg::ST_HOLD;
        end else begin
          root_start = 1'b1;
          state_nxt  = bcf_pkg::ST_ROOT;
        end
      end
      bcf_pkg::ST_ROOT: begin
        if (root_done) begin
          res_load           = 1'b1;
          res_nxt.clearance  = (root_val > RW'(32767)) ? 16'sh7FFF : signed'(16'(root_val));
          res_nxt.inside_res = 1'b0;
          state_nxt          = bcf_pkg::ST_HOLD;
        end
      end
      bcf_pkg::ST_HOLD: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = bcf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bcf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcf_pkg::ST_FILL;
    end else begin
      state_r <= state_nxt;
    end
  end

  // per-op setup: products first, then the grown half sizes
  logic signed [26:0] f_sx, f_sy;
  logic [25:0]        f_gr;
  assign f_sx = $signed({1'b0, frame_r}) * in_r.speed_x;
  assign f_sy = $signed({1'b0, frame_r}) * in_r.speed_y;
  assign f_gr = {1'b0, frame_r} * {1'b0, in_r.spread_growth};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r     <= '0;
      fill_val_r  <= bcf_pkg::LIMIT_RST;
      fill_sq_r   <= 30'(bcf_pkg::LIMIT_RST * bcf_pkg::LIMIT_RST);
      fill_addr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fill_we) fill_addr_r <= fill_addr_r + 1'b1;
      if (in_fire && bcf_pkg::op_t'(in_data.op) == bcf_pkg::OP_CLEAR) begin
        frame_r     <= in_data.frame_number;
        fill_val_r  <= limit_r;
        fill_sq_r   <= limit_r * limit_r;
        fill_addr_r <= '0;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) in_r <= in_data;
    if (res_load) res_r <= res_nxt;
    if (out_load) out_r <= res_r;
    if (state_r == bcf_pkg::ST_SETUP) begin
      spread_r <= bcf_pkg::sat_c(bcf_pkg::zx15(in_r.base_spread) +
                  bcf_pkg::sat_c({{(WW-26){1'b0}}, f_gr}, COORD_BITS), COORD_BITS);
      px_r <= bcf_pkg::sat_c(bcf_pkg::sx16(in_r.box_x) +
              bcf_pkg::sat_c({{(WW-27){f_sx[26]}}, f_sx}, COORD_BITS), COORD_BITS);
      py_r <= bcf_pkg::sat_c(bcf_pkg::sx16(in_r.box_y) +
              bcf_pkg::sat_c({{(WW-27){f_sy[26]}}, f_sy}, COORD_BITS), COORD_BITS);
    end
    if (state_r == bcf_pkg::ST_HALF) begin
      hx_r <= bcf_pkg::sat_c(bcf_pkg::sat_c(bcf_pkg::zx15(margin_r) +
              bcf_pkg::zx15(in_r.half_size_x), COORD_BITS) + spread_r, COORD_BITS);
      hy_r <= bcf_pkg::sat_c(bcf_pkg::sat_c(bcf_pkg::zx15(margin_r) +
              bcf_pkg::zx15(in_r.half_size_y), COORD_BITS) + spread_r, COORD_BITS);
      col_r   <= '0;
      row_r   <= '0;
      base_r  <= '0;
      acc_x_r <= '0;
      acc_y_r <= '0;
    end else if (walk_fire) begin
      if (col_r == CCW'(cols_eff - 1'b1)) begin
        col_r   <= '0;
        acc_x_r <= '0;
        row_r   <= row_r + 1'b1;
        base_r  <= AW'(base_r + AW'(MAX_COLUMNS));
        acc_y_r <= bcf_pkg::sat_c(acc_y_r + bcf_pkg::zx15(y_pitch_r), COORD_BITS);
      end else begin
        col_r   <= col_r + 1'b1;
        acc_x_r <= bcf_pkg::sat_c(acc_x_r + bcf_pkg::zx15(x_pitch_r), COORD_BITS);
      end
    end
  end

  // cell pipeline: sample -> gaps + RAM read -> squares -> compare + write
  logic signed [WW-1:0] dx, dy, adx, ady;
  logic [UW-1:0]        ux, uy;
  assign dx  = b_sx_r - px_r;
  assign dy  = b_sy_r - py_r;
  assign adx = (dx < 0) ? -dx : dx;
  assign ady = (dy < 0) ? -dy : dy;
  assign ux  = (c_gx_r > 0) ? c_gx_r[UW-1:0] : '0;
  assign uy  = (c_gy_r > 0) ? c_gy_r[UW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
    end else begin
      b_valid_r <= walk_fire;
      c_valid_r <= b_valid_r;
      d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    b_sx_r   <= bcf_pkg::sat_c(bcf_pkg::sx16(x_org_r) + acc_x_r, COORD_BITS);
    b_sy_r   <= bcf_pkg::sat_c(bcf_pkg::sx16(y_org_r) + acc_y_r, COORD_BITS);
    b_addr_r <= AW'(base_r + AW'(col_r));
    c_gx_r   <= bcf_pkg::sat_c(bcf_pkg::sat_c(adx, COORD_BITS) - hx_r, COORD_BITS);
    c_gy_r   <= bcf_pkg::sat_c(bcf_pkg::sat_c(ady, COORD_BITS) - hy_r, COORD_BITS);
    c_addr_r <= b_addr_r;
    d_gx_r   <= c_gx_r;
    d_gy_r   <= c_gy_r;
    d_addr_r <= c_addr_r;
    d_sqx_r  <= ux * ux;
    d_sqy_r  <= uy * uy;
    d_dep_r  <= dep_rdata;
    d_sq_r   <= sq_rdata;
  end

  logic                 d_in;
  logic signed [WW-1:0] d_max, d_dep_w;
  logic [SQW-1:0]       d_sq_new;
  assign d_in     = (d_gx_r <= 0) && (d_gy_r <= 0);
  assign d_max    = (d_gx_r > d_gy_r) ? d_gx_r : d_gy_r;
  assign d_dep_w  = {{(WW-DW){d_dep_r[DW-1]}}, d_dep_r};
  assign d_sq_new = SQW'(d_sqx_r) + SQW'(d_sqy_r);

  always_comb begin
    if (fill_we) begin
      waddr     = fill_addr_r;
      dep_we    = 1'b1;
      sq_we     = 1'b1;
      dep_wdata = DW'(fill_val_r);
      sq_wdata  = SQW'(fill_sq_r);
    end else begin
      waddr     = d_addr_r;
      dep_we    = d_valid_r && d_in && (d_max < d_dep_w);
      sq_we     = d_valid_r && !d_in && (d_dep_w > 0) && (d_sq_new < d_sq_r);
      dep_wdata = d_max[DW-1:0];
      sq_wdata  = d_sq_new;
    end
  end

  assign raddr     = (state_r == bcf_pkg::ST_IDLE) ? rd_cell : b_addr_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    (dep_we || sq_we) |-> (state_r == bcf_pkg::ST_FILL || d_valid_r))
    else $error("store write outside fill or cell pipeline");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!b_valid_r && !c_valid_r && !d_valid_r))
    else $error("item taken while cell pipeline busy");

  a_root_state: assert property (@(posedge clk) disable iff (!rst_n)
    root_done |-> state_r == bcf_pkg::ST_ROOT)
    else $error("root result outside root wait");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == bcf_pkg::ST_HOLD))
    else $error("result shown without a finished read");

endmodule

### hw/rtl/bcf_ram.sv
`timescale 1ns / 1ps
module bcf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/bcf_root.sv
`timescale 1ns / 1ps
module bcf_root #(
  parameter int VW = 30,
  localparam int NI = (VW + 1) / 2,
  localparam int PW = 2 * NI,
  localparam int CW = $clog2(NI + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [VW-1:0] value,
  output logic          done,
  output logic [NI:0]   root
);

  logic [PW-1:0] val_r;
  logic [NI+1:0] rem_r;
  logic [NI-1:0] q_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [NI+2:0] rem_sh;
  logic [NI+2:0] trial;

  // remainder never exceeds twice the partial root, so its top bit stays clear
  assign rem_sh = {rem_r[NI:0], val_r[PW-1 -: 2]};
  assign trial  = {1'b0, q_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        val_r  <= PW'(value);
        rem_r  <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        val_r <= val_r << 2;
        if (rem_sh >= trial) begin
          rem_r <= (NI+2)'(rem_sh - trial);
          q_r   <= {q_r[NI-2:0], 1'b1};
        end else begin
          rem_r <= (NI+2)'(rem_sh);
          q_r   <= {q_r[NI-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NI - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // round to nearest: remainder above the root means the upper neighbor is closer
  assign done = done_r;
  assign root = (rem_r > (NI+2)'(q_r)) ? ((NI+1)'(q_r) + 1'b1) : (NI+1)'(q_r);

endmodule
